// ===== src/risqrt_pkg.sv =====
`timescale 1ns / 1ps

package risqrt_pkg;

  // Fixed field widths of the transactions.
  localparam int OPERAND_W = 32;
  localparam int ROOT_W    = 16;

  // Default word width that the square root works on.
  localparam int DATA_WIDTH_DEF = 32;

  // Control that travels down the chain of cells with each operand.
  typedef struct packed {
    logic valid;
    logic neg;
  } risqrt_ctl_t;

endpackage

// ===== src/risqrt_if.sv =====
`timescale 1ns / 1ps

// Operand channel.
interface risqrt_in_if import risqrt_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OPERAND_W-1:0] operand;

  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

// Result channel.
interface risqrt_out_if import risqrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root;
  logic              out_of_bounds;

  modport source (output valid, output root, output out_of_bounds, input ready);
  modport sink   (input valid, input root, input out_of_bounds, output ready);
endinterface

// ===== src/risqrt_cell.sv =====
`timescale 1ns / 1ps

// One digit step of the square root. The cell holds one operand in flight
// and hands its remainder and partial root to the next cell.
module risqrt_cell import risqrt_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int STEP       = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  risqrt_ctl_t           up_ctl_i,
  input  logic [DATA_WIDTH-1:0] up_rem_i,
  input  logic [DATA_WIDTH-1:0] up_root_i,
  output logic                  up_ready_o,
  output risqrt_ctl_t           dn_ctl_o,
  output logic [DATA_WIDTH-1:0] dn_rem_o,
  output logic [DATA_WIDTH-1:0] dn_root_o,
  input  logic                  dn_ready_i
);

  localparam int                SHIFT = DATA_WIDTH - 2 - 2 * STEP;
  localparam logic [DATA_WIDTH:0] BIT_VAL = (DATA_WIDTH + 1)'(1) << SHIFT;

  logic                  valid_q, valid_d;
  logic                  neg_q;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] root_q, root_d;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   root_sum;
  logic                  take;
  logic                  load;

  // The cell frees up when it is empty or when its content moves on.
  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_ctl_i.valid && up_ready_o;

  // Trial subtraction for this root digit.
  always_comb begin
    trial    = {1'b0, up_root_i} + BIT_VAL;
    take     = {1'b0, up_rem_i} >= trial;
    rem_d    = up_rem_i;
    root_sum = {1'b0, up_root_i};
    if (take) begin
      rem_d    = DATA_WIDTH'({1'b0, up_rem_i} - trial);
      root_sum = {1'b0, up_root_i} + (BIT_VAL << 1);
    end
    root_d  = DATA_WIDTH'(root_sum >> 1);
    valid_d = up_ready_o ? up_ctl_i.valid : valid_q;
  end

  // Valid flag under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Operand state, loaded with each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      neg_q  <= up_ctl_i.neg;
    end
  end

  assign dn_ctl_o.valid = valid_q;
  assign dn_ctl_o.neg   = neg_q;
  assign dn_rem_o       = rem_q;
  assign dn_root_o      = root_q;

  // A transaction taken in must show up in the cell next cycle.
  a_load_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("cell did not capture an accepted transaction");

  // A blocked cell keeps its content unchanged.
  a_hold_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !dn_ready_i |=> valid_q && $stable(rem_q) && $stable(root_q))
    else $error("blocked cell lost or changed its content");

endmodule

// ===== src/risqrt_round.sv =====
`timescale 1ns / 1ps

// Final stage: rounds the truncated root to nearest, applies the sign check
// and holds the result until the result channel takes it.
module risqrt_round import risqrt_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  risqrt_ctl_t           up_ctl_i,
  input  logic [DATA_WIDTH-1:0] up_rem_i,
  input  logic [DATA_WIDTH-1:0] up_root_i,
  output logic                  up_ready_o,
  risqrt_out_if.source          out_o
);

  logic              valid_q, valid_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic              oob_q;
  logic              load;
  logic [DATA_WIDTH:0] rounded;

  assign up_ready_o = !valid_q || out_o.ready;
  assign load       = up_ctl_i.valid && up_ready_o;

  // Round up when the remainder exceeds the truncated root.
  always_comb begin
    rounded = {1'b0, up_root_i} + (DATA_WIDTH + 1)'(up_rem_i > up_root_i);
    root_d  = up_ctl_i.neg ? '0 : ROOT_W'(rounded);
    valid_d = up_ready_o ? up_ctl_i.valid : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      root_q <= root_d;
      oob_q  <= up_ctl_i.neg;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.root          = root_q;
  assign out_o.out_of_bounds = oob_q;

  // An out-of-bounds result always carries a zero root.
  a_oob_zero_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && oob_q |-> root_q == '0)
    else $error("out-of-bounds result with a non-zero root");

  // A negative operand reaching this stage yields the error flag.
  a_neg_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && up_ctl_i.neg |=> valid_q && oob_q)
    else $error("negative operand did not raise the error flag");

endmodule

// ===== src/rounded_integer_square_root_core.sv =====
`timescale 1ns / 1ps

// An accepted operand passes one cell per root digit, then the rounding
// register, before its result is valid, longer under stall. Throughput: one
// transaction per cycle when not stalled; the chain closes up bubbles, so
// operands are taken while a finished result waits, until the chain is full.
// Reset clears only the valid flags of the cells and the result register.
module rounded_integer_square_root_core import risqrt_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  risqrt_in_if.sink    in_i,
  risqrt_out_if.source out_o
);

  localparam int NUM_CELLS = DATA_WIDTH / 2;

  risqrt_ctl_t           ctl  [NUM_CELLS+1];
  logic [DATA_WIDTH-1:0] rem  [NUM_CELLS+1];
  logic [DATA_WIDTH-1:0] root [NUM_CELLS+1];
  logic                  rdy  [NUM_CELLS+1];
  logic [DATA_WIDTH-1:0] operand_x;

  // Only the low DATA_WIDTH bits count; the top one of them is the sign.
  assign operand_x  = DATA_WIDTH'($unsigned(in_i.operand));
  assign ctl[0].valid = in_i.valid;
  assign ctl[0].neg   = operand_x[DATA_WIDTH-1];
  assign rem[0]       = operand_x;
  assign root[0]      = '0;
  assign in_i.ready   = rdy[0];

  // Chain of digit cells, from the highest power of four downwards.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    risqrt_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .STEP       (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_ctl_i   (ctl[k]),
      .up_rem_i   (rem[k]),
      .up_root_i  (root[k]),
      .up_ready_o (rdy[k]),
      .dn_ctl_o   (ctl[k+1]),
      .dn_rem_o   (rem[k+1]),
      .dn_root_o  (root[k+1]),
      .dn_ready_i (rdy[k+1])
    );
  end

  // Rounding and result register.
  risqrt_round #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_ctl_i   (ctl[NUM_CELLS]),
    .up_rem_i   (rem[NUM_CELLS]),
    .up_root_i  (root[NUM_CELLS]),
    .up_ready_o (rdy[NUM_CELLS]),
    .out_o      (out_o)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench import risqrt_pkg::*; ();

  localparam int DW             = DATA_WIDTH_DEF;
  localparam int N_RANDOM       = 530;
  localparam int QUIET_FROM     = 430;
  localparam int WATCHDOG_LIMIT = 2000;

  // Expected contents of one result transaction.
  typedef struct {
    logic [ROOT_W-1:0] root;
    logic              out_of_bounds;
  } root_result_t;

  // Holds the roots still owed by the block and checks them in order.
  class root_scoreboard;
    root_result_t pending_roots[$];
    int unsigned  n_mismatch;
    int unsigned  n_checked;
    int unsigned  n_negative;
    int unsigned  n_rounded_up;

    // Digit-by-digit square root, rounded to nearest.
    function root_result_t rounded_root(logic [OPERAND_W-1:0] operand);
      logic [63:0]  rem;
      logic [63:0]  acc;
      logic [63:0]  four_pow;
      root_result_t res;
      rem = 64'(operand);
      if (DW < 64) begin
        rem = rem & ((64'd1 << DW) - 64'd1);
      end
      res.out_of_bounds = rem[DW-1];
      res.root          = '0;
      if (res.out_of_bounds) begin
        n_negative++;
        return res;
      end
      acc      = '0;
      four_pow = 64'd1 << (DW - 2);
      while (four_pow > rem) begin
        four_pow = four_pow >> 2;
      end
      while (four_pow != 0) begin
        if (rem >= acc + four_pow) begin
          rem = rem - (acc + four_pow);
          acc = acc + (four_pow << 1);
        end
        acc      = acc >> 1;
        four_pow = four_pow >> 2;
      end
      // A remainder above the truncated root means the value lies past r + 1/2.
      if (rem > acc) begin
        acc = acc + 64'd1;
        n_rounded_up++;
      end
      res.root = acc[ROOT_W-1:0];
      return res;
    endfunction

    function void note_operand(logic [OPERAND_W-1:0] operand);
      pending_roots.push_back(rounded_root(operand));
    endfunction

    function void check_result(logic [ROOT_W-1:0] root, logic out_of_bounds);
      root_result_t exp_res;
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result, root %0d out_of_bounds %0b",
                 $time, root, out_of_bounds);
        n_mismatch++;
        return;
      end
      exp_res = pending_roots.pop_front();
      n_checked++;
      if (root !== exp_res.root) begin
        $display("%0t: root mismatch, expected %0d, actual %0d",
                 $time, exp_res.root, root);
        n_mismatch++;
      end
      if (out_of_bounds !== exp_res.out_of_bounds) begin
        $display("%0t: out_of_bounds mismatch, expected %0b, actual %0b",
                 $time, exp_res.out_of_bounds, out_of_bounds);
        n_mismatch++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_n;
  logic quiet;
  int   idle_cycles;

  root_scoreboard root_sb;

  risqrt_in_if  in_if ();
  risqrt_out_if out_if ();

  rounded_integer_square_root_core #(
    .DATA_WIDTH(DW)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Corner operands: zero, small values, rounding boundaries, the largest
  // positive value and negatives.
  logic [OPERAND_W-1:0] directed_ops[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd8, 32'd15, 32'd16,
    32'd24, 32'd99, 32'd100, 32'd2147395600, 32'd2147441940, 32'd2147441941,
    32'h7FFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'hC000_0001
  };

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sends one operand, with an occasional idle burst before it.
  task automatic send_operand(input logic [OPERAND_W-1:0] operand);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.operand <= operand;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Random operand, weighted towards near squares and spread magnitudes.
  function automatic logic [OPERAND_W-1:0] random_operand();
    longint unsigned r;
    longint          val;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        r   = $urandom_range(0, 46340);
        val = longint'(r * r) + longint'($urandom_range(0, 2 * r + 2)) - longint'(r);
        if (val < 0) val = 0;
        if (val > 64'sh7FFF_FFFF) val = 64'sh7FFF_FFFF;
        return val[OPERAND_W-1:0];
      end
      3:       return OPERAND_W'($urandom_range(0, 255));
      4, 5:    return $urandom >> $urandom_range(1, 31);
      6:       return $urandom | 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Result side: ready drops in random bursts, except in the quiet phase.
  initial begin
    int stall_cnt;
    stall_cnt = 0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (stall_cnt > 0) begin
        out_if.ready <= 1'b0;
        stall_cnt--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall_cnt = $urandom_range(1, 6) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
      @(posedge clk_i);
    end
  end

  // Transaction monitors on both channels.
  always @(posedge clk_i) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      root_sb.note_operand(in_if.operand);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      root_sb.check_result(out_if.root, out_if.out_of_bounds);
    end
  end

  // Watchdog: ends the run if no transaction happens for too long.
  always @(posedge clk_i) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired after %0d idle cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed operands, random operands, drain.
  initial begin
    root_sb       = new();
    quiet         = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.operand <= '0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[i]) begin
      send_operand(directed_ops[i]);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= QUIET_FROM);
      send_operand(random_operand());
    end
    in_if.valid <= 1'b0;

    while (root_sb.pending_roots.size() != 0) @(posedge clk_i);
    repeat (DW / 2 + 8) @(posedge clk_i);

    $display("Checked %0d roots: %0d negative operands, %0d rounded up.",
             root_sb.n_checked, root_sb.n_negative, root_sb.n_rounded_up);
    $display("Stimulus covered corner operands, near squares and random values.");
    if (root_sb.n_mismatch == 0 && root_sb.pending_roots.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
